// ===== src/quoted_atom_escaper_defines.svh =====
// ----------------------------------------------------------------------------
// Quoted atom escaper assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_ATOM_ESCAPER_DEFINES_SVH
`define QUOTED_ATOM_ESCAPER_DEFINES_SVH

// Same-cycle implication.
`define QAE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define QAE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/qae_pkg.sv =====
// ----------------------------------------------------------------------------
// Quoted atom escaper package
// Item types, character codes and the small decode functions of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qae_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_first;
        logic [1:0] bytes_after;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_RAW,
        JOB_PAIR,
        JOB_HEX1,
        JOB_HEX2
    } job_kind_t;

    // One classified input byte, waiting to be expanded by the back end.
    typedef struct packed {
        logic      open_quote;
        logic      close_quote;
        job_kind_t kind;
        logic [7:0] b0;
        logic [7:0] b1;
    } job_t;

    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [7:0] UTF2_MASK = 8'hE0;
    localparam logic [7:0] UTF2_LEAD = 8'hC0;
    localparam logic [7:0] UTF3_MASK = 8'hF0;
    localparam logic [7:0] UTF3_LEAD = 8'hE0;
    localparam logic [7:0] UTF4_MASK = 8'hF8;
    localparam logic [7:0] UTF4_LEAD = 8'hF0;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
        begin
            r = 8'h30 + {4'h0, v};
        end
        else
        begin
            r = 8'h41 + {4'h0, v} - 8'd10;
        end
        return r;
    endfunction

    // Letter of a single-character escape, or zero when the byte has none.
    function automatic logic [7:0] esc_letter(input logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            8'h07:   r = 8'h61;
            8'h08:   r = 8'h62;
            8'h0C:   r = 8'h66;
            8'h0A:   r = 8'h6E;
            8'h0D:   r = 8'h72;
            8'h09:   r = 8'h74;
            8'h0B:   r = 8'h76;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] utf8_followers(input logic [7:0] b);
        logic [1:0] r;
        if ((b & UTF2_MASK) == UTF2_LEAD)
        begin
            r = 2'd1;
        end
        else if ((b & UTF3_MASK) == UTF3_LEAD)
        begin
            r = 2'd2;
        end
        else if ((b & UTF4_MASK) == UTF4_LEAD)
        begin
            r = 2'd3;
        end
        else
        begin
            r = 2'd0;
        end
        return r;
    endfunction

endpackage

// ===== src/qae_in_if.sv =====
// ----------------------------------------------------------------------------
// Quoted atom escaper input channel
// Valid/ready channel carrying one raw atom byte per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qae_in_if;
    import qae_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/qae_out_if.sv =====
// ----------------------------------------------------------------------------
// Quoted atom escaper output channel
// Valid/ready channel carrying one byte of escaped text per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qae_out_if;
    import qae_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/qae_front.sv =====
// ----------------------------------------------------------------------------
// Quoted atom escaper front end
// Accepts raw bytes, tracks UTF-8 followers and classifies each byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qae_front (
    input  logic          clk,
    input  logic          rst_n,
    qae_in_if.sink        item,
    input  logic          queue_full,
    output logic          push,
    output qae_pkg::job_t job
);
    import qae_pkg::*;

    logic [1:0] pass_left_reg;
    logic [1:0] pass_left_next;
    logic [1:0] pass_eff;
    logic [1:0] followers;
    logic [7:0] b;
    logic [7:0] letter;

    assign item.ready = !queue_full;
    assign push       = item.valid && !queue_full;

    assign b         = item.data.data_byte;
    assign pass_eff  = item.data.is_first ? 2'd0 : pass_left_reg;
    assign followers = utf8_followers(b);
    assign letter    = esc_letter(b);

    always_comb
    begin
        job.open_quote  = item.data.is_first;
        job.close_quote = (item.data.bytes_after == 2'd0);
        job.kind        = JOB_RAW;
        job.b0          = b;
        job.b1          = b;
        pass_left_next  = pass_eff;

        if (pass_eff != 2'd0)
        begin
            pass_left_next = pass_eff - 2'd1;
        end
        else if (b == CH_QUOTE || b == CH_BSLASH)
        begin
            job.kind = JOB_PAIR;
        end
        else if (letter != 8'h00)
        begin
            job.kind = JOB_PAIR;
            job.b0   = CH_BSLASH;
            job.b1   = letter;
        end
        else if (b < CH_SPACE || b >= CH_DEL)
        begin
            if (followers == 2'd0 || followers > item.data.bytes_after)
            begin
                job.kind = (b[7:4] != 4'h0) ? JOB_HEX2 : JOB_HEX1;
                job.b0   = hex_digit(b[7:4]);
                job.b1   = hex_digit(b[3:0]);
            end
            else
            begin
                pass_left_next = followers;
            end
        end

        if (item.data.bytes_after == 2'd0)
        begin
            pass_left_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_left_reg <= 2'd0;
        end
        else if (push)
        begin
            pass_left_reg <= pass_left_next;
        end
    end
endmodule

// ===== src/qae_fifo.sv =====
// ----------------------------------------------------------------------------
// Quoted atom escaper job queue
// Small show-ahead queue of classified bytes between front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qae_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  qae_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output qae_pkg::job_t head_job
);
    import qae_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end
endmodule

// ===== src/qae_back.sv =====
// ----------------------------------------------------------------------------
// Quoted atom escaper back end
// Expands the job at the queue head into output bytes, one per cycle while the output side takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quoted_atom_escaper_defines.svh"

module qae_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  qae_pkg::job_t head_job,
    output logic          pop,
    qae_out_if.source     result
);
    import qae_pkg::*;

    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;
    out_item_t  out_item_next;

    logic [2:0] body_len;
    logic [2:0] total;
    logic [2:0] body_idx;
    logic [7:0] body_byte;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       load;

    always_comb
    begin
        unique case (head_job.kind)
            JOB_RAW:  body_len = 3'd1;
            JOB_PAIR: body_len = 3'd2;
            JOB_HEX1: body_len = 3'd4;
            JOB_HEX2: body_len = 3'd5;
            default:  body_len = 3'd1;
        endcase
    end

    assign total    = body_len + {2'b00, head_job.open_quote} + {2'b00, head_job.close_quote};
    assign body_idx = step_reg - {2'b00, head_job.open_quote};

    always_comb
    begin
        body_byte = head_job.b0;
        unique case (head_job.kind)
            JOB_RAW:
            begin
                body_byte = head_job.b0;
            end
            JOB_PAIR:
            begin
                body_byte = (body_idx == 3'd0) ? head_job.b0 : head_job.b1;
            end
            JOB_HEX1:
            begin
                case (body_idx)
                    3'd0:    body_byte = CH_BSLASH;
                    3'd1:    body_byte = CH_X;
                    3'd2:    body_byte = head_job.b1;
                    default: body_byte = CH_BSLASH;
                endcase
            end
            JOB_HEX2:
            begin
                case (body_idx)
                    3'd0:    body_byte = CH_BSLASH;
                    3'd1:    body_byte = CH_X;
                    3'd2:    body_byte = head_job.b0;
                    3'd3:    body_byte = head_job.b1;
                    default: body_byte = CH_BSLASH;
                endcase
            end
            default:
            begin
                body_byte = head_job.b0;
            end
        endcase
    end

    always_comb
    begin
        if (head_job.open_quote && step_reg == 3'd0)
        begin
            cur_byte = CH_QUOTE;
        end
        else if (body_idx < body_len)
        begin
            cur_byte = body_byte;
        end
        else
        begin
            cur_byte = CH_QUOTE;
        end
    end

    assign cur_last = (step_reg == total - 3'd1);
    assign load     = head_valid && (!out_valid_reg || result.ready);
    assign pop      = load && cur_last;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (load)
        begin
            out_valid_next            = 1'b1;
            out_item_next.out_byte    = cur_byte;
            out_item_next.last_of_run = cur_last;
            step_next                 = cur_last ? 3'd0 : step_reg + 3'd1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_item_reg;

    `QAE_ASSERT_NOW(a_step_in_range, head_valid, step_reg < total, "step past end of job")
    `QAE_ASSERT_NOW(a_step_needs_job, step_reg != 3'd0, head_valid, "job left mid-expansion")
    `QAE_ASSERT_NEXT(a_step_rewinds, pop, step_reg == 3'd0, "step not cleared after job")
endmodule

// ===== src/quoted_atom_escaper.sv =====
// ----------------------------------------------------------------------------
// Quoted atom escaper
// Turns the bytes of an atom name into its single-quoted, escaped form.
// ----------------------------------------------------------------------------
// The block takes one raw byte per request and delivers the escaped text one
// byte per request, with last_of_run marking the final byte caused by each
// input byte. Each input byte yields one to seven output bytes, and the back
// end emits one of them per cycle while the output side takes them. The front
// end classifies a byte in the cycle it is taken and accepts a new byte every
// cycle while the DEPTH-entry job queue has room; the output register lets a
// new byte be produced in the same cycle the previous one is taken.
`timescale 1ns / 1ps

module quoted_atom_escaper #(
    parameter int DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    qae_in_if.sink    item,
    qae_out_if.source result
);
    import qae_pkg::*;

    logic push;
    logic pop;
    logic queue_full;
    logic head_valid;
    job_t push_job;
    job_t head_job;

    qae_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    qae_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    qae_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .result     (result)
    );
endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Quoted atom escaper testbench
// Sends atom names byte by byte, in well-formed atoms, cut-off atoms and
// loose bytes, and checks every escaped output byte and its run marker
// against a prediction kept in a scoreboard class. Both handshake sides
// stall at random, the output side holds off long enough to fill the block,
// and the input side pauses until the output has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import qae_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    class quote_scoreboard;
        out_item_t  expected_q[$];
        logic [1:0] follow_left;
        int         errors;
        int         checked;

        function new();
            follow_left = 2'd0;
            errors = 0;
            checked = 0;
        endfunction

        function logic [7:0] nibble_char(input logic [3:0] v);
            return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
        endfunction

        function logic [7:0] escape_char(input logic [7:0] b);
            logic [7:0] r;
            case (b)
                8'h07:   r = "a";
                8'h08:   r = "b";
                8'h0C:   r = "f";
                8'h0A:   r = "n";
                8'h0D:   r = "r";
                8'h09:   r = "t";
                8'h0B:   r = "v";
                default: r = 8'h00;
            endcase
            return r;
        endfunction

        function logic [1:0] follow_count(input logic [7:0] b);
            logic [1:0] r;
            if ((b & UTF2_MASK) == UTF2_LEAD)
            begin
                r = 2'd1;
            end
            else if ((b & UTF3_MASK) == UTF3_LEAD)
            begin
                r = 2'd2;
            end
            else if ((b & UTF4_MASK) == UTF4_LEAD)
            begin
                r = 2'd3;
            end
            else
            begin
                r = 2'd0;
            end
            return r;
        endfunction

        function void note_input(input in_item_t it);
            logic [7:0] seq[$];
            logic [7:0] b;
            logic [7:0] letter;
            logic [1:0] n;
            out_item_t  e;
            b = it.data_byte;
            letter = escape_char(b);
            if (it.is_first)
            begin
                follow_left = 2'd0;
                seq.push_back(CH_QUOTE);
            end
            if (follow_left != 2'd0)
            begin
                seq.push_back(b);
                follow_left = follow_left - 2'd1;
            end
            else if (b == CH_QUOTE || b == CH_BSLASH)
            begin
                seq.push_back(b);
                seq.push_back(b);
            end
            else if (letter != 8'h00)
            begin
                seq.push_back(CH_BSLASH);
                seq.push_back(letter);
            end
            else if (b < CH_SPACE || b >= CH_DEL)
            begin
                n = follow_count(b);
                if (n == 2'd0 || n > it.bytes_after)
                begin
                    seq.push_back(CH_BSLASH);
                    seq.push_back(CH_X);
                    if (b[7:4] != 4'h0)
                    begin
                        seq.push_back(nibble_char(b[7:4]));
                    end
                    seq.push_back(nibble_char(b[3:0]));
                    seq.push_back(CH_BSLASH);
                end
                else
                begin
                    seq.push_back(b);
                    follow_left = n;
                end
            end
            else
            begin
                seq.push_back(b);
            end
            if (it.bytes_after == 2'd0)
            begin
                follow_left = 2'd0;
                seq.push_back(CH_QUOTE);
            end
            foreach (seq[i])
            begin
                e.out_byte = seq[i];
                e.last_of_run = (i == seq.size() - 1);
                expected_q.push_back(e);
            end
        endfunction

        function void check_result(input out_item_t got);
            out_item_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output byte %h last %b", $time,
                         got.out_byte, got.last_of_run);
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                errors++;
                $display("%0t: out_byte expected %h actual %h", $time,
                         want.out_byte, got.out_byte);
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                errors++;
                $display("%0t: last_of_run expected %b actual %b", $time,
                         want.last_of_run, got.last_of_run);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    qae_in_if  in_ch ();
    qae_out_if out_ch ();

    quoted_atom_escaper uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch)
    );

    quote_scoreboard sb;
    bit send_idle_on;
    bit recv_idle_on;
    bit hold_req;
    int n_sent;
    int n_atoms;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles, %0d bytes still due", cycle_count,
                         sb.pending());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (recv_idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                sb.check_result(out_ch.data);
            end
        end
    end

    task automatic send_item(input in_item_t it);
        if (send_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_input(it);
        n_sent++;
    endtask

    task automatic send_atom(input byte_q_t bytes, input int extra);
        in_item_t it;
        int left;
        for (int i = 0; i < bytes.size(); i++)
        begin
            left = bytes.size() - 1 - i + extra;
            it.data_byte = bytes[i];
            it.is_first = (i == 0);
            it.bytes_after = (left > 3) ? 2'd3 : left[1:0];
            send_item(it);
        end
        n_atoms++;
    endtask

    task automatic send_loose(input logic [7:0] b, input logic first, input logic [1:0] after);
        in_item_t it;
        it.data_byte = b;
        it.is_first = first;
        it.bytes_after = after;
        send_item(it);
    endtask

    function automatic void add_chunk(ref byte_q_t q);
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind <= 3)
        begin
            q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        else if (kind == 4)
        begin
            q.push_back($urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
        end
        else if (kind == 5)
        begin
            q.push_back(8'($urandom_range(8'h07, 8'h0D)));
        end
        else if (kind == 6)
        begin
            q.push_back($urandom_range(0, 4) == 0 ? CH_DEL : 8'($urandom_range(0, 8'h1F)));
        end
        else if (kind == 7)
        begin
            q.push_back($urandom_range(0, 2) == 0 ? 8'($urandom_range(8'hF8, 8'hFF))
                                                 : 8'($urandom_range(8'h80, 8'hBF)));
        end
        else
        begin
            n = $urandom_range(1, 3);
            case (n)
                1:       q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                2:       q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                default: q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
            endcase
            repeat (n)
            begin
                q.push_back($urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(8'h80, 8'hBF)));
            end
        end
    endfunction

    task automatic run_random(input int n_items);
        byte_q_t q;
        int start;
        int len;
        int pick;
        start = n_sent;
        while (n_sent - start < n_items)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 18)
            begin
                q = {};
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14)
                                                  : $urandom_range(1, 8);
                while (q.size() < len)
                begin
                    add_chunk(q);
                end
                if (pick < 16)
                begin
                    send_atom(q, 0);
                end
                else
                begin
                    q = q[0:$urandom_range(0, q.size() - 1)];
                    send_atom(q, $urandom_range(1, 3));
                end
            end
            else
            begin
                send_loose(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           2'($urandom_range(0, 3)));
            end
        end
    endtask

    initial
    begin
        byte_q_t q;
        sb = new();
        n_sent = 0;
        n_atoms = 0;
        hold_req = 1'b0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        q = {8'h00};
        send_atom(q, 0);
        q = {8'hFF};
        send_atom(q, 0);
        q = {CH_QUOTE, CH_BSLASH};
        send_atom(q, 0);
        q = {8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        send_atom(q, 0);
        q = {8'h1F, CH_SPACE, CH_DEL};
        send_atom(q, 0);
        q = {8'hC3, 8'hA9};
        send_atom(q, 0);
        // The lead byte wants two followers but only one remains.
        q = {8'hE2, 8'h82};
        send_atom(q, 0);
        q = {8'hF0, 8'h9F, 8'h98, 8'h80};
        send_atom(q, 0);
        // A sequence cut short by a new atom, then an atom that closes
        // while followers are still due.
        q = {8'hF0, 8'h9F};
        send_atom(q, 3);
        send_loose(8'hE2, 1'b1, 2'd3);
        send_loose(8'h82, 1'b0, 2'd0);

        run_random(40);

        send_idle_on = 1'b0;
        hold_req = 1'b1;
        run_random(24);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end

        recv_idle_on = 1'b0;
        run_random(30);
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d input bytes in %0d atoms plus loose bytes, checked %0d output bytes.",
                 n_sent, n_atoms, sb.checked);
        $display("Covered escapes, doubling, hex, UTF-8 pass-through and cut-off sequences.");
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== quoted_atom_escaper.f =====
+incdir+src
src/qae_pkg.sv
src/qae_in_if.sv
src/qae_out_if.sv
src/qae_front.sv
src/qae_fifo.sv
src/qae_back.sv
src/quoted_atom_escaper.sv
dv/tb_top.sv
